// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/pds_pkg.sv =====
// package for the pid drive block: word types, config struct, register indexes
// no dependencies
`default_nettype none
package pds_pkg;

    localparam int unsigned TICK_MS   = 10;
    localparam int unsigned SETTLE_MS = 100;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_I_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_D_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_WIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DRIVE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_BAND = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd7;

    localparam logic [11:0] MAX_DRIVE_RST = 12'd3072;

    typedef struct packed {
        logic signed [15:0] err_value;
        logic               restart;
    } t_in_word;

    typedef struct packed {
        logic signed [12:0] drive;
        logic               settled;
        logic               timed_out;
    } t_out_word;

    typedef struct packed {
        logic [15:0] p_gain;
        logic [15:0] i_gain;
        logic [15:0] d_gain;
        logic [11:0] slew_step;
        logic [14:0] integral_window;
        logic [11:0] max_drive;
        logic [14:0] exit_band;
        logic [15:0] timeout_ms;
    } t_cfg;

    // registered products and flags between the two compute stages
    typedef struct packed {
        logic signed [32:0] p_prod;
        logic        [47:0] i_prod;
        logic signed [33:0] d_prod;
        logic               restart;
        logic               settled;
        logic               timed_out;
    } t_terms;

    // millisecond counter step, saturating at all ones
    function automatic logic [15:0] count_up(input logic [15:0] c);
        logic [16:0] sum;
        sum = {1'b0, c} + 17'(TICK_MS);
        return sum[16] ? 16'hFFFF : sum[15:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/pds_term.sv =====
// first compute stage: error history, gated integral, timers and the three products
// depends on pds_pkg
`default_nettype none
module pds_term (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire pds_pkg::t_cfg   i_cfg,
    input  wire pds_pkg::t_in_word i_in,
    input  wire logic            i_load,
    output pds_pkg::t_terms      o_terms
);
    import pds_pkg::*;

    logic signed [15:0] r_last_error;
    logic        [31:0] r_integral;
    logic        [15:0] r_elapsed_ms;
    logic        [15:0] r_settled_ms;

    logic signed [15:0] base_err;
    logic        [31:0] base_int;
    logic        [15:0] base_el;
    logic        [15:0] base_st;
    logic signed [16:0] deriv;
    logic               gate;
    logic        [32:0] int_sum;
    logic        [31:0] n_integral;
    logic        [15:0] err_u;
    logic        [15:0] mag;
    logic               in_band;
    logic        [15:0] n_settled_ms;
    logic        [15:0] n_elapsed_ms;

    // restart wipes the history before this word is used
    assign base_err = i_in.restart ? 16'sd0 : r_last_error;
    assign base_int = i_in.restart ? 32'd0  : r_integral;
    assign base_el  = i_in.restart ? 16'd0  : r_elapsed_ms;
    assign base_st  = i_in.restart ? 16'd0  : r_settled_ms;

    // exact derivative
    assign deriv = {i_in.err_value[15], i_in.err_value} - {base_err[15], base_err};

    // integral accumulates only with a nonzero i gain and inside the window, otherwise clears
    assign err_u   = i_in.err_value;
    assign gate    = (i_cfg.i_gain != 16'd0) && !err_u[15]
                     && (err_u[14:0] <= i_cfg.integral_window);
    assign int_sum = {1'b0, base_int} + {17'd0, err_u};
    assign n_integral = !gate      ? 32'd0 :
                        int_sum[32] ? 32'hFFFF_FFFF : int_sum[31:0];

    // settle and elapsed timers
    assign mag          = err_u[15] ? (~err_u + 16'd1) : err_u;
    assign in_band      = mag < {1'b0, i_cfg.exit_band};
    assign n_settled_ms = in_band ? count_up(base_st) : 16'd0;
    assign n_elapsed_ms = count_up(base_el);

    // products and flags for the next stage
    always_comb begin
        o_terms.p_prod    = i_in.err_value * $signed({1'b0, i_cfg.p_gain});
        o_terms.i_prod    = n_integral * i_cfg.i_gain;
        o_terms.d_prod    = deriv * $signed({1'b0, i_cfg.d_gain});
        o_terms.restart   = i_in.restart;
        o_terms.settled   = in_band && (n_settled_ms > 16'(SETTLE_MS));
        o_terms.timed_out = (i_cfg.timeout_ms != 16'd0) && (n_elapsed_ms > i_cfg.timeout_ms);
    end

    // running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error <= '0;
            r_integral   <= '0;
            r_elapsed_ms <= '0;
            r_settled_ms <= '0;
        end else if (i_load) begin
            r_last_error <= i_in.err_value;
            r_integral   <= n_integral;
            r_elapsed_ms <= n_elapsed_ms;
            r_settled_ms <= n_settled_ms;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pds_limit.sv =====
// second compute stage: pid sum, drive clamp and slew limit against the last drive
// depends on pds_pkg
`default_nettype none
module pds_limit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pds_pkg::t_cfg  i_cfg,
    input  wire pds_pkg::t_terms i_terms,
    input  wire logic           i_load,
    output pds_pkg::t_out_word  o_word
);
    import pds_pkg::*;

    logic signed [12:0] r_last_drive;

    logic signed [51:0] total;
    logic signed [51:0] lim;
    logic signed [12:0] max_s;
    logic signed [12:0] clamped;
    logic signed [12:0] prev;
    logic signed [13:0] change;
    logic signed [13:0] step;
    logic signed [13:0] lim_change;
    logic signed [12:0] n_drive;

    // exact pid sum
    assign total = {{19{i_terms.p_prod[32]}}, i_terms.p_prod}
                 + $signed({4'd0, i_terms.i_prod})
                 + {{18{i_terms.d_prod[33]}}, i_terms.d_prod};

    // clamp to +-max_drive, then floor to q5.8
    assign lim   = $signed({32'd0, i_cfg.max_drive, 8'd0});
    assign max_s = $signed({1'b0, i_cfg.max_drive});
    always_comb begin
        priority if (total > lim) begin
            clamped = max_s;
        end else if (total < -lim) begin
            clamped = -max_s;
        end else begin
            clamped = total[20:8];
        end
    end

    // slew limit relative to the previous drive
    assign prev   = i_terms.restart ? 13'sd0 : r_last_drive;
    assign change = {clamped[12], clamped} - {prev[12], prev};
    assign step   = $signed({2'b0, i_cfg.slew_step});
    always_comb begin
        priority if (change > step) begin
            lim_change = step;
        end else if (change < -step) begin
            lim_change = -step;
        end else begin
            lim_change = change;
        end
    end
    assign n_drive = (i_cfg.slew_step == 12'd0) ? clamped : prev + lim_change[12:0];

    always_comb begin
        o_word.drive     = n_drive;
        o_word.settled   = i_terms.settled;
        o_word.timed_out = i_terms.timed_out;
    end

    // last drive
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_drive <= '0;
        end else if (i_load) begin
            r_last_drive <= n_drive;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pid_drive_with_slew_and_settle.sv =====
// Usage: PID drive stage with output clamp, slew limit and settle/timeout flags.
// Input channel: i_in_valid / o_in_stall carry one word per control tick
// (signed Q8.8 error and a restart bit); a word is taken when valid is high
// and stall is low. Output channel: o_out_valid / i_out_stall carry one word
// per input word: signed Q5.8 drive, settled flag, timed-out flag.
// Config: write i_cfg_data to register i_cfg_idx while i_cfg_we is high;
// write only while no word is in flight.
// Path: an accepted word passes the input register, the product register and
// the output register in that order before output valid rises; a stall can
// hold it in any of them.
// Throughput: one word per cycle while the receiver does not stall; the integral
// add plus its multiply and the sum/clamp/slew path each fit in one stage.
// Reset (synchronous, active low) clears the running state, the stage valid bits
// and the config registers but for max_drive, which comes up at 3072 (12 V).
// When the receiver stalls, the output word holds and stages behind it keep
// filling; input stall rises only once every stage holds a word.
// depends on pds_pkg, pds_term, pds_limit
`default_nettype none
module pid_drive_with_slew_and_settle (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire pds_pkg::t_in_word             i_in_word,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output pds_pkg::t_out_word                 o_out_word,
    input  wire logic                          i_cfg_we,
    input  wire logic [pds_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [pds_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pds_pkg::*;

    t_cfg      r_cfg;
    logic      r_v1;
    t_in_word  r_in;
    logic      r_v2;
    t_terms    r_terms;
    logic      r_ov;
    t_out_word r_out;

    t_terms    n_terms;
    t_out_word n_out;
    logic      in_acc;
    logic      out_take;
    logic      ov_free;
    logic      mv2;
    logic      s2_free;
    logic      mv1;
    logic      s1_free;

    // pipeline flow
    assign out_take   = r_ov && !i_out_stall;
    assign ov_free    = !r_ov || out_take;
    assign mv2        = r_v2 && ov_free;
    assign s2_free    = !r_v2 || mv2;
    assign mv1        = r_v1 && s2_free;
    assign s1_free    = !r_v1 || mv1;
    assign in_acc     = i_in_valid && s1_free;
    assign o_in_stall = !s1_free;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.p_gain          <= '0;
            r_cfg.i_gain          <= '0;
            r_cfg.d_gain          <= '0;
            r_cfg.slew_step       <= '0;
            r_cfg.integral_window <= '0;
            r_cfg.max_drive       <= MAX_DRIVE_RST;
            r_cfg.exit_band       <= '0;
            r_cfg.timeout_ms      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_P_GAIN:    r_cfg.p_gain          <= i_cfg_data;
                CFG_I_GAIN:    r_cfg.i_gain          <= i_cfg_data;
                CFG_D_GAIN:    r_cfg.d_gain          <= i_cfg_data;
                CFG_SLEW_STEP: r_cfg.slew_step       <= i_cfg_data[11:0];
                CFG_INT_WIN:   r_cfg.integral_window <= i_cfg_data[14:0];
                CFG_MAX_DRIVE: r_cfg.max_drive       <= i_cfg_data[11:0];
                CFG_EXIT_BAND: r_cfg.exit_band       <= i_cfg_data[14:0];
                CFG_TIMEOUT:   r_cfg.timeout_ms      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pds_term u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (r_in),
        .i_load  (mv1),
        .o_terms (n_terms)
    );

    pds_limit u_limit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_terms (r_terms),
        .i_load  (mv2),
        .o_word  (n_out)
    );

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (in_acc) begin
                r_v1 <= 1'b1;
            end else if (mv1) begin
                r_v1 <= 1'b0;
            end
            if (mv1) begin
                r_v2 <= 1'b1;
            end else if (mv2) begin
                r_v2 <= 1'b0;
            end
            if (mv2) begin
                r_ov <= 1'b1;
            end else if (out_take) begin
                r_ov <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_word;
        end
        if (mv1) begin
            r_terms <= n_terms;
        end
        if (mv2) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

endmodule
`default_nettype wire

// ===== rtl/pds_check.sv =====
// port-level checker for the pid drive block, bound to the top level
// depends on pds_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module pds_check (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire pds_pkg::t_out_word             o_out_word
);
    import pds_pkg::*;

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // stalled output word stays and holds
    `ASSERT_NEXT(a_out_hold_valid, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `ASSERT_NEXT(a_out_hold_word, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_word))

    // input stalls only when an output word is blocked
    `ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // nothing on the output right after reset
    `ASSERT_ALWAYS(a_reset_empty, i_clk, i_rst_n, !$past(!i_rst_n) || !o_out_valid)

    // an accepted word reaches the output when the receiver does not stall on its way
    `ASSERT_NEXT(a_latency, i_clk, i_rst_n, in_acc ##1 !i_out_stall ##1 !i_out_stall, o_out_valid)

endmodule

bind pid_drive_with_slew_and_settle pds_check u_pds_check (.*);
`default_nettype wire

// ===== sim/tb_pid_drive_with_slew_and_settle.sv =====
// self-checking bench for pid_drive_with_slew_and_settle: directed table, random
// register settings with random ticks, and a closing in-window run with a live integral
// depends on pds_pkg and the block's rtl only
`timescale 1ns / 1ps

module tb_pid_drive_with_slew_and_settle;
    import pds_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES = 60;
    localparam int unsigned PHASES = 11;
    localparam int unsigned WORDS_PER_PHASE = 150;
    localparam int unsigned SOAK_WORDS = 150;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // one line of the directed table: a register write or a tick
    typedef struct packed {
        t_row_kind          kind;
        logic [2:0]         idx;
        logic [15:0]        data;
        logic signed [15:0] err;
        logic               restart;
        int                 reps;
        logic               typed;
        t_out_word          want;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_word   i_in_word;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_word  o_out_word;
    logic       i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // bench-side copy of registers and loop state
    t_cfg        model_cfg;
    int          prev_err;
    logic [31:0] int_acc;
    int          prev_drive;
    logic [15:0] run_ms;
    logic [15:0] band_ms;

    t_out_word drive_due[$];
    logic      typed_row;
    t_out_word typed_word;
    bit        quiet;
    int        hold_asks;
    int        hold_seen;
    int        hold_left;
    int        mismatch_cnt;
    int        words_in;
    int        words_out;
    int        settings_cnt;
    int unsigned cycles;

    pid_drive_with_slew_and_settle i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // millisecond timer step, stops at all ones
    function automatic logic [15:0] ms_bump(input logic [15:0] c);
        int unsigned s;
        s = c + TICK_MS;
        return (s > 32'hFFFF) ? 16'hFFFF : 16'(s);
    endfunction

    function automatic void clear_loop();
        prev_err = 0;
        int_acc = '0;
        prev_drive = 0;
        run_ms = '0;
        band_ms = '0;
    endfunction

    // one control tick: pid sum, clamp, slew, settle and timeout flags
    function automatic t_out_word next_drive_word(input t_in_word w);
        int err;
        int deriv;
        int drv;
        int chg;
        int step;
        int mag;
        longint total;
        longint lim;
        longint unsigned acc;
        logic in_band;
        t_out_word r;
        err = w.err_value;
        if (w.restart)
            clear_loop();
        deriv = err - prev_err;

        // integral only runs inside the window
        if (model_cfg.i_gain != 0 && err >= 0 && err <= int'(model_cfg.integral_window)) begin
            acc = longint'(int_acc) + longint'(err);
            int_acc = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
        end else begin
            int_acc = '0;
        end

        total = longint'(err) * longint'(model_cfg.p_gain)
              + longint'(int_acc) * longint'(model_cfg.i_gain)
              + longint'(deriv) * longint'(model_cfg.d_gain);

        lim = longint'(model_cfg.max_drive) * 256;
        if (total > lim)
            drv = int'(model_cfg.max_drive);
        else if (total < -lim)
            drv = -int'(model_cfg.max_drive);
        else
            drv = int'(total >>> 8);

        // slew limit from the previous drive
        if (model_cfg.slew_step != 0) begin
            chg = drv - prev_drive;
            step = int'(model_cfg.slew_step);
            if (chg > step)
                chg = step;
            else if (chg < -step)
                chg = -step;
            drv = prev_drive + chg;
        end

        mag = (err < 0) ? -err : err;
        in_band = mag < int'(model_cfg.exit_band);
        band_ms = in_band ? ms_bump(band_ms) : 16'd0;
        run_ms = ms_bump(run_ms);
        prev_drive = drv;
        prev_err = err;

        r.drive = 13'(drv);
        r.settled = in_band && (band_ms > SETTLE_MS);
        r.timed_out = (model_cfg.timeout_ms != 0) && (run_ms > model_cfg.timeout_ms);
        return r;
    endfunction

    function automatic void take_cfg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_P_GAIN:    model_cfg.p_gain = data;
            CFG_I_GAIN:    model_cfg.i_gain = data;
            CFG_D_GAIN:    model_cfg.d_gain = data;
            CFG_SLEW_STEP: model_cfg.slew_step = data[11:0];
            CFG_INT_WIN:   model_cfg.integral_window = data[14:0];
            CFG_MAX_DRIVE: model_cfg.max_drive = data[11:0];
            CFG_EXIT_BAND: model_cfg.exit_band = data[14:0];
            CFG_TIMEOUT:   model_cfg.timeout_ms = data;
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int exp);
        $display("mismatch on output word %0d: %s got %0d expected %0d",
                 words_out, what, got, exp);
        mismatch_cnt++;
    endtask

    // accept words, predict, and check results against the oldest prediction
    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        if (i_rst_n) begin
            if (i_cfg_we)
                take_cfg(i_cfg_idx, i_cfg_data);
            if (i_in_valid && !o_in_stall) begin
                want = next_drive_word(i_in_word);
                if (typed_row)
                    want = typed_word;
                drive_due.push_back(want);
                words_in++;
            end
            if (o_out_valid && !i_out_stall) begin
                got = o_out_word;
                words_out++;
                if (drive_due.size() == 0) begin
                    flag_mismatch("word with nothing pending, drive", int'(got.drive), 0);
                end else begin
                    want = drive_due.pop_front();
                    if (got.drive !== want.drive)
                        flag_mismatch("drive", int'(got.drive), int'(want.drive));
                    if (got.settled !== want.settled)
                        flag_mismatch("settled", int'(got.settled), int'(want.settled));
                    if (got.timed_out !== want.timed_out)
                        flag_mismatch("timed_out", int'(got.timed_out),
                                      int'(want.timed_out));
                end
            end
        end
    end

    // receiver: random stalls, a quiet stretch, and long hold-offs on request
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_asks != hold_seen) begin
            i_out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_seen <= hold_asks;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < 7);
        end
    end

    // present one word, with an occasional gap in front
    task automatic put_word(input t_in_word w, input logic typed, input t_out_word tw);
        int gap;
        if (!quiet && $urandom_range(99) < 7) begin
            gap = $urandom_range(5, 1);
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_word = w;
        typed_row = typed;
        typed_word = tw;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop sending and wait for every pending result
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (drive_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_out_word out_word(input int drv, input logic s, input logic t);
        t_out_word r;
        r.drive = 13'(drv);
        r.settled = s;
        r.timed_out = t;
        return r;
    endfunction

    function automatic t_row item_row(input logic signed [15:0] err, input logic restart,
                                      input int reps, input logic typed, input t_out_word want);
        t_row r;
        r = '0;
        r.kind = ROW_ITEM;
        r.err = err;
        r.restart = restart;
        r.reps = reps;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [2:0] idx, input logic [15:0] data);
        t_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    // register value: extremes, small, anywhere in range, or raw 16 bits
    function automatic logic [15:0] pick_val(input int unsigned hi);
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'(hi);
            2: return 16'($urandom_range((hi < 512) ? hi : 512));
            3: return 16'($urandom);
            default: return 16'($urandom_range(hi));
        endcase
    endfunction

    task automatic write_all_random();
        write_reg(CFG_P_GAIN, pick_val(65535));
        write_reg(CFG_I_GAIN, pick_val(65535));
        write_reg(CFG_D_GAIN, pick_val(65535));
        write_reg(CFG_SLEW_STEP, pick_val(3072));
        write_reg(CFG_INT_WIN, pick_val(32767));
        write_reg(CFG_MAX_DRIVE, pick_val(3072));
        write_reg(CFG_EXIT_BAND, pick_val(32767));
        write_reg(CFG_TIMEOUT, pick_val(65535));
        settings_cnt++;
    endtask

    initial begin
        t_row rows[$];
        t_row row;
        t_in_word w;
        t_out_word none;
        int cur_err;
        int sel;
        logic signed [15:0] raw16;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        typed_row = 1'b0;
        typed_word = '0;
        quiet = 1'b0;
        hold_asks = 0;
        hold_seen = 0;
        hold_left = 0;
        mismatch_cnt = 0;
        words_in = 0;
        words_out = 0;
        settings_cnt = 0;
        cycles = 0;
        none = '0;

        // register values after reset
        model_cfg = '0;
        model_cfg.max_drive = MAX_DRIVE_RST;
        clear_loop();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset values, clamp extremes, masked register, gating, slew-in
        rows.push_back(item_row(0, 1'b0, 1, 1'b1, out_word(0, 1'b0, 1'b0)));
        rows.push_back(item_row(32767, 1'b0, 1, 1'b1, out_word(0, 1'b0, 1'b0)));
        rows.push_back(item_row(-32768, 1'b0, 1, 1'b1, out_word(0, 1'b0, 1'b0)));
        rows.push_back(cfg_row(CFG_P_GAIN, 16'd256));
        rows.push_back(item_row(32767, 1'b0, 1, 1'b1, out_word(3072, 1'b0, 1'b0)));
        rows.push_back(item_row(-32768, 1'b0, 1, 1'b1, out_word(-3072, 1'b0, 1'b0)));
        rows.push_back(item_row(100, 1'b0, 1, 1'b1, out_word(100, 1'b0, 1'b0)));
        // all ones lands as 4095 in the 12 bit clamp
        rows.push_back(cfg_row(CFG_MAX_DRIVE, 16'hFFFF));
        rows.push_back(item_row(32767, 1'b0, 1, 1'b1, out_word(4095, 1'b0, 1'b0)));
        rows.push_back(item_row(-32768, 1'b0, 1, 1'b1, out_word(-4095, 1'b0, 1'b0)));
        rows.push_back(cfg_row(CFG_I_GAIN, 16'hFFFF));
        rows.push_back(cfg_row(CFG_D_GAIN, 16'hFFFF));
        rows.push_back(cfg_row(CFG_INT_WIN, 16'd100));
        rows.push_back(cfg_row(CFG_EXIT_BAND, 16'h7FFF));
        rows.push_back(cfg_row(CFG_TIMEOUT, 16'd30));
        // integral inside, at the window edge, above it, negative; then the band edges
        rows.push_back(item_row(50, 1'b1, 1, 1'b0, none));
        rows.push_back(item_row(100, 1'b0, 1, 1'b0, none));
        rows.push_back(item_row(101, 1'b0, 1, 1'b0, none));
        rows.push_back(item_row(-1, 1'b0, 1, 1'b0, none));
        rows.push_back(item_row(-32768, 1'b0, 1, 1'b0, none));
        rows.push_back(item_row(32767, 1'b0, 1, 1'b0, none));
        // ramp up under the slew limit, then shrink the clamp under it
        rows.push_back(cfg_row(CFG_SLEW_STEP, 16'd256));
        rows.push_back(item_row(0, 1'b1, 1, 1'b0, none));
        rows.push_back(item_row(32767, 1'b0, 3, 1'b0, none));
        rows.push_back(cfg_row(CFG_MAX_DRIVE, 16'd256));
        rows.push_back(item_row(32767, 1'b0, 2, 1'b0, none));

        foreach (rows[k]) begin
            row = rows[k];
            if (row.kind == ROW_CFG) begin
                drain_results();
                write_reg(row.idx, row.data);
            end else begin
                w.err_value = row.err;
                w.restart = row.restart;
                put_word(w, row.typed, row.want);
                w.restart = 1'b0;
                for (int r = 1; r < row.reps; r++)
                    put_word(w, row.typed, row.want);
            end
        end
        settings_cnt++;

        // random: new register setting per phase, mostly decaying moves
        cur_err = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            write_all_random();
            if (ph == 3)
                hold_asks++;
            quiet = (ph == 5);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (ph == 7 && n == WORDS_PER_PHASE / 2)
                    drain_results();
                w.restart = ($urandom_range(99) < 2) || (n == 0 && $urandom_range(1) == 1);
                sel = $urandom_range(99);
                if (w.restart || sel < 10) begin
                    raw16 = 16'($urandom);
                    cur_err = raw16;
                end else if (sel < 15) begin
                    case ($urandom_range(3))
                        0: cur_err = -32768;
                        1: cur_err = 32767;
                        2: cur_err = -1;
                        default: cur_err = 0;
                    endcase
                end else if (sel < 30) begin
                    cur_err = $urandom_range(model_cfg.integral_window);
                end else begin
                    cur_err = cur_err - cur_err / 8 + $urandom_range(6) - 3;
                end
                if (cur_err > 32767)
                    cur_err = 32767;
                if (cur_err < -32768)
                    cur_err = -32768;
                w.err_value = 16'(cur_err);
                put_word(w, 1'b0, none);
            end
        end
        quiet = 1'b0;

        // closing run: large in-window errors keep the integral and both timers climbing
        drain_results();
        write_reg(CFG_P_GAIN, pick_val(65535));
        write_reg(CFG_I_GAIN, 16'd1);
        write_reg(CFG_D_GAIN, pick_val(65535));
        write_reg(CFG_SLEW_STEP, pick_val(3072));
        write_reg(CFG_INT_WIN, 16'h7FFF);
        write_reg(CFG_MAX_DRIVE, pick_val(3072));
        write_reg(CFG_EXIT_BAND, 16'h7FFF);
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        settings_cnt++;
        for (int n = 0; n < SOAK_WORDS; n++) begin
            w.restart = (n == 0);
            w.err_value = 16'($urandom_range(32766, 32000));
            put_word(w, 1'b0, none);
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (drive_due.size() != 0)
            flag_mismatch("results never delivered, count", 0, drive_due.size());

        $display("run covered %0d ticks in, %0d drive words out, %0d register settings",
                 words_in, words_out, settings_cnt);
        $display("including clamp and slew extremes, integral gating and a long in-window run");
        if (mismatch_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pds_pkg.sv
rtl/pds_term.sv
rtl/pds_limit.sv
rtl/pid_drive_with_slew_and_settle.sv
rtl/pds_check.sv
sim/tb_pid_drive_with_slew_and_settle.sv
